// File: hdl/jsv_pkg.sv
// Shared types and result codes for the JSON syntax validator.
`default_nettype none

package jsv_pkg;

  // Result codes carried on error_kind.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SYNTAX = 2'd1;
  localparam logic [1:0] ERR_NEST   = 2'd2;

  // Container kinds held on the bracket stack.
  localparam logic KIND_ARRAY  = 1'b0;
  localparam logic KIND_OBJECT = 1'b1;

  // Commands from the scanner to the bracket stack.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic kind;
  } stack_cmd_t;

  // Status of the bracket stack as seen by the scanner.
  typedef struct packed {
    logic empty;
    logic one;
    logic full;
    logic top_kind;
  } stack_stat_t;

endpackage

`default_nettype wire

// File: hdl/jsv_in_if.sv
// Byte channel into the validator: one document byte per beat.
`default_nettype none

interface jsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/jsv_out_if.sv
// Result channel out of the validator: one verdict per document.
`default_nettype none

interface jsv_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [1:0] error_kind;

  modport source (output valid, output accepted, output error_kind, input ready);
  modport sink   (input valid, input accepted, input error_kind, output ready);
endinterface

`default_nettype wire

// File: hdl/jsv_stack.sv
// Bracket-kind stack: top entry in a register, entries below it in a memory.
`default_nettype none

module jsv_stack
  import jsv_pkg::*;
#(
  parameter int MAX_NEST = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  stack_cmd_t cmd,
  output stack_stat_t stat
);

  localparam int LW = $clog2(MAX_NEST + 1);
  localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

  logic [LW-1:0] level;
  logic [LW-1:0] level_next;
  logic          top;
  logic          below;
  logic          mem [MAX_NEST];
  logic [LW:0]   waddr_full;
  logic [LW:0]   raddr_full;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // Depth update; a clear at the end of a document wins over everything.
  always_comb begin
    level_next = level;
    if (cmd.clear) begin
      level_next = '0;
    end else if (cmd.push) begin
      level_next = level + LW'(1);
    end else if (cmd.pop && (level != '0)) begin
      level_next = level - LW'(1);
    end
  end

  // The old top is written just below the new one; the entry under the
  // next top is fetched in advance so a pop never waits on the memory read.
  assign waddr_full = {1'b0, level} - (LW + 1)'(1);
  assign raddr_full = {1'b0, level_next} - (LW + 1)'(2);
  assign waddr      = waddr_full[AW-1:0];
  assign raddr      = raddr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  // Memory and the two cached entries; no reset, each entry is written
  // by a push before it can be read.
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      if (level != '0) begin
        mem[waddr] <= top;
      end
      top   <= cmd.kind;
      below <= top;
    end else begin
      if (cmd.pop && !cmd.clear) begin
        top <= below;
      end
      below <= mem[raddr];
    end
  end

  assign stat.empty    = (level == '0);
  assign stat.one      = (level == LW'(1));
  assign stat.full     = (level == LW'(MAX_NEST));
  assign stat.top_kind = (level == '0) ? KIND_ARRAY : top;

endmodule

`default_nettype wire

// File: hdl/jsv_scanner.sv
// Scanner state machine: checks one document byte per beat.
`default_nettype none

module jsv_scanner
  import jsv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  stack_stat_t      stat,
  output stack_cmd_t       cmd,
  output logic             accepted,
  output logic [1:0]       error_kind
);

  typedef enum logic [4:0] {
    PH_ROOT, PH_ITEM, PH_KEY, PH_KEY_ESC, PH_COLON, PH_VALUE, PH_STR, PH_STR_ESC,
    PH_LIT, PH_N_SIGN, PH_N_ZERO, PH_N_INT, PH_N_FRAC, PH_N_EXP, PH_N_EXPSIGN,
    PH_N_EXPDIG, PH_AFTER, PH_DONE
  } phase_t;

  localparam logic [7:0] CTRL_LIMIT = 8'd32;
  localparam logic [7:0] DEL_CHAR   = 8'd127;

  // Positions in the literal text "nulltruefalse".
  localparam logic [3:0] LIT_NULL  = 4'd1;
  localparam logic [3:0] LIT_TRUE  = 4'd5;
  localparam logic [3:0] LIT_FALSE = 4'd9;
  localparam logic [3:0] END_NULL  = 4'd3;
  localparam logic [3:0] END_TRUE  = 4'd7;
  localparam logic [3:0] END_FALSE = 4'd12;

  function automatic logic [7:0] lit_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:  c = "n";
      4'd1:  c = "u";
      4'd2:  c = "l";
      4'd3:  c = "l";
      4'd4:  c = "t";
      4'd5:  c = "r";
      4'd6:  c = "u";
      4'd7:  c = "e";
      4'd8:  c = "f";
      4'd9:  c = "a";
      4'd10: c = "l";
      4'd11: c = "s";
      4'd12: c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic legal_escape(input logic [7:0] b);
    return (b == "\"") || (b == "\\") || (b == "/") || (b == "b") || (b == "f") ||
           (b == "n") || (b == "r") || (b == "t") || (b == "u");
  endfunction

  phase_t     phase, phase_next, eff;
  logic       empty_so_far, empty_next;
  logic [3:0] lit_pos, lit_next;
  logic       failed, failed_next;
  logic [1:0] fail_kind, kind_next;
  logic       err_syntax, err_nest;
  logic       do_start, do_open, open_kind, do_close;
  logic       is_num, num_end, is_e, is_close, ok;

  // Next-state logic for one byte.
  always_comb begin
    phase_next = phase;
    empty_next = empty_so_far;
    lit_next   = lit_pos;
    err_syntax = 1'b0;
    err_nest   = 1'b0;
    do_start   = 1'b0;
    do_open    = 1'b0;
    open_kind  = KIND_ARRAY;
    do_close   = 1'b0;
    num_end    = 1'b0;
    eff        = phase;
    is_e       = (data_byte == "e") || (data_byte == "E");
    is_close   = (data_byte == (stat.top_kind ? 8'("}") : 8'("]")));
    is_num     = phase inside {PH_N_SIGN, PH_N_ZERO, PH_N_INT, PH_N_FRAC,
                               PH_N_EXP, PH_N_EXPSIGN, PH_N_EXPDIG};
    cmd        = '0;

    if (!failed) begin
      // Number phases: a byte that cannot continue the number ends it.
      if (is_num) begin
        case (phase)
          PH_N_SIGN: begin
            if (data_byte == "0") phase_next = PH_N_ZERO;
            else if (is_digit(data_byte)) phase_next = PH_N_INT;
            else err_syntax = 1'b1;
          end
          PH_N_EXP: begin
            if ((data_byte == "+") || (data_byte == "-")) phase_next = PH_N_EXPSIGN;
            else if (is_digit(data_byte)) phase_next = PH_N_EXPDIG;
            else err_syntax = 1'b1;
          end
          PH_N_EXPSIGN: begin
            if (is_digit(data_byte)) phase_next = PH_N_EXPDIG;
            else err_syntax = 1'b1;
          end
          PH_N_ZERO: begin
            if (data_byte == ".") phase_next = PH_N_FRAC;
            else if (is_e) phase_next = PH_N_EXP;
            else num_end = 1'b1;
          end
          PH_N_INT: begin
            if (is_digit(data_byte)) phase_next = PH_N_INT;
            else if (data_byte == ".") phase_next = PH_N_FRAC;
            else if (is_e) phase_next = PH_N_EXP;
            else num_end = 1'b1;
          end
          PH_N_FRAC: begin
            if (is_digit(data_byte)) phase_next = PH_N_FRAC;
            else if (is_e) phase_next = PH_N_EXP;
            else num_end = 1'b1;
          end
          default: begin
            if (!is_digit(data_byte)) num_end = 1'b1;
          end
        endcase
        if (num_end) begin
          phase_next = PH_AFTER;
          eff        = PH_AFTER;
        end
      end

      // Structural phases, including the byte that ended a number.
      if (!is_num || num_end) begin
        unique case (eff)
          PH_ROOT: begin
            if (!is_ws(data_byte)) begin
              if (data_byte == "[") begin
                do_open = 1'b1;
              end else if (data_byte == "{") begin
                do_open   = 1'b1;
                open_kind = KIND_OBJECT;
              end else begin
                err_syntax = 1'b1;
              end
            end
          end
          PH_ITEM: begin
            if (!is_ws(data_byte)) begin
              if (is_close) begin
                if (empty_so_far) do_close = 1'b1;
                else err_syntax = 1'b1;
              end else if (stat.top_kind) begin
                if (data_byte == "\"") begin
                  empty_next = 1'b0;
                  phase_next = PH_KEY;
                end else begin
                  err_syntax = 1'b1;
                end
              end else begin
                do_start = 1'b1;
              end
            end
          end
          PH_KEY, PH_STR: begin
            if (data_byte == "\"") begin
              phase_next = (eff == PH_KEY) ? PH_COLON : PH_AFTER;
            end else if (data_byte == "\\") begin
              phase_next = (eff == PH_KEY) ? PH_KEY_ESC : PH_STR_ESC;
            end else if ((data_byte < CTRL_LIMIT) || (data_byte == DEL_CHAR)) begin
              err_syntax = 1'b1;
            end
          end
          PH_KEY_ESC, PH_STR_ESC: begin
            if (legal_escape(data_byte)) begin
              phase_next = (eff == PH_KEY_ESC) ? PH_KEY : PH_STR;
            end else begin
              err_syntax = 1'b1;
            end
          end
          PH_COLON: begin
            if (!is_ws(data_byte)) begin
              if (data_byte == ":") phase_next = PH_VALUE;
              else err_syntax = 1'b1;
            end
          end
          PH_VALUE: begin
            if (!is_ws(data_byte)) do_start = 1'b1;
          end
          PH_LIT: begin
            if (data_byte == lit_char(lit_pos)) begin
              if ((lit_pos == END_NULL) || (lit_pos == END_TRUE) ||
                  (lit_pos == END_FALSE)) begin
                phase_next = PH_AFTER;
              end else begin
                lit_next = lit_pos + 4'd1;
              end
            end else begin
              err_syntax = 1'b1;
            end
          end
          PH_AFTER: begin
            if (!is_ws(data_byte)) begin
              if (data_byte == ",") begin
                empty_next = 1'b0;
                phase_next = PH_ITEM;
              end else if (is_close) begin
                do_close = 1'b1;
              end else begin
                err_syntax = 1'b1;
              end
            end
          end
          PH_DONE: begin
            if (!is_ws(data_byte)) err_syntax = 1'b1;
          end
          default: err_syntax = 1'b1;
        endcase
      end

      // Start of a value inside an array or after a colon.
      if (do_start) begin
        empty_next = 1'b0;
        if (data_byte == "n") begin
          lit_next = LIT_NULL;  phase_next = PH_LIT;
        end else if (data_byte == "t") begin
          lit_next = LIT_TRUE;  phase_next = PH_LIT;
        end else if (data_byte == "f") begin
          lit_next = LIT_FALSE; phase_next = PH_LIT;
        end else if (data_byte == "\"") begin
          phase_next = PH_STR;
        end else if (data_byte == "[") begin
          do_open = 1'b1;
        end else if (data_byte == "{") begin
          do_open   = 1'b1;
          open_kind = KIND_OBJECT;
        end else if ((data_byte == "+") || (data_byte == "-")) begin
          phase_next = PH_N_SIGN;
        end else if (data_byte == "0") begin
          phase_next = PH_N_ZERO;
        end else if (is_digit(data_byte)) begin
          phase_next = PH_N_INT;
        end else begin
          err_syntax = 1'b1;
        end
      end

      // Opening a container, refused when the stack is full.
      if (do_open) begin
        if (stat.full) begin
          err_nest = 1'b1;
        end else begin
          cmd.push   = advance;
          cmd.kind   = open_kind;
          empty_next = 1'b1;
          phase_next = PH_ITEM;
        end
      end

      // Closing the innermost container.
      if (do_close) begin
        cmd.pop    = advance;
        phase_next = (stat.one || stat.empty) ? PH_DONE : PH_AFTER;
      end
    end

    // The first error is kept; later bytes are ignored.
    failed_next = failed;
    kind_next   = fail_kind;
    if (!failed && (err_syntax || err_nest)) begin
      failed_next = 1'b1;
      kind_next   = err_nest ? ERR_NEST : ERR_SYNTAX;
    end

    cmd.clear  = advance && last_byte;
    ok         = !failed_next && (phase_next == PH_DONE);
    accepted   = ok;
    error_kind = failed_next ? kind_next : (ok ? ERR_NONE : ERR_SYNTAX);
  end

  // Scanner state; everything returns to reset after the final byte.
  always_ff @(posedge clk) begin
    if (rst || (advance && last_byte)) begin
      phase        <= PH_ROOT;
      empty_so_far <= 1'b1;
      lit_pos      <= 4'd0;
      failed       <= 1'b0;
      fail_kind    <= ERR_NONE;
    end else if (advance) begin
      phase        <= phase_next;
      empty_so_far <= empty_next;
      lit_pos      <= lit_next;
      failed       <= failed_next;
      fail_kind    <= kind_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/json_syntax_validator.sv
// Top level of the JSON syntax validator: input register, scanner, result register.
`default_nettype none

// The block takes a document one byte per beat on byte_ch and gives one
// verdict on result_ch for each byte marked last_byte: accepted, and the
// kind of the first error (none, syntax, nesting too deep). It accepts a
// byte in every cycle unless a final byte waits on a full result register;
// the verdict is registered when the final byte leaves the input register.
// The rate is set by the scanner loop, which updates the phase register
// and the top of the bracket stack once per byte; the top entry and the one
// beneath it are held in registers, so pushes and pops never wait on the
// stack memory read. The stack memory holds MAX_NEST entries and needs no
// clearing after reset, since an entry is always written by a push before
// it is read. A new byte is taken while a verdict still waits; only a final
// byte that meets a full result register stalls.

module json_syntax_validator
  import jsv_pkg::*;
#(
  parameter int MAX_NEST = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  jsv_in_if.sink    byte_ch,
  jsv_out_if.source result_ch
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_adv;
  stack_cmd_t  cmd;
  stack_stat_t stat;
  logic        res_accepted;
  logic [1:0]  res_kind;
  logic        out_valid;
  logic        out_accepted;
  logic [1:0]  out_kind;

  // A buffered byte moves on unless it is final and the result is stalled.
  assign s1_adv        = s1_valid && (!s1_last || !out_valid || result_ch.ready);
  assign byte_ch.ready = !s1_valid || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      s1_valid <= byte_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      s1_byte <= byte_ch.data_byte;
      s1_last <= byte_ch.last_byte;
    end
  end

  jsv_scanner u_scanner (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_adv),
    .data_byte  (s1_byte),
    .last_byte  (s1_last),
    .stat       (stat),
    .cmd        (cmd),
    .accepted   (res_accepted),
    .error_kind (res_kind)
  );

  jsv_stack #(
    .MAX_NEST (MAX_NEST)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      out_accepted <= res_accepted;
      out_kind     <= res_kind;
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.accepted   = out_accepted;
  assign result_ch.error_kind = out_kind;

`ifndef SYNTHESIS
  // A fresh verdict only ever follows a final byte leaving the input register.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(s1_adv && s1_last))
    else $error("result appeared without a final byte");

  // A held byte is not overwritten while it waits.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_byte) && $stable(s1_last)))
    else $error("buffered byte lost while stalled");

  // An accepted document carries no error code, and the code is a known one.
  a_verdict_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_accepted == (out_kind == ERR_NONE)) &&
                   ((out_kind == ERR_NONE) || (out_kind == ERR_SYNTAX) ||
                    (out_kind == ERR_NEST))))
    else $error("inconsistent verdict");
`endif

endmodule

`default_nettype wire
